// ----- hw/rtl/dic_pkg.sv -----
package dic_pkg;

	localparam int NUMBER_FIELD_BYTES = 16;
	localparam int LEN_W = 11;
	localparam int POS_W = LEN_W + 1;
	localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(1440);
	localparam logic [LEN_W-1:0] POS_MAX = {LEN_W{1'b1}};
	localparam int NUM_W = 54;
	localparam int CNT_W = 32;
	localparam int OUT_W = 2 + NUM_W + 2 * CNT_W;

	// Queue depth must be a power of two so the pointers wrap on their own.
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);

	typedef enum logic [1:0] {
		VERDICT_OK       = 2'd0,
		VERDICT_CHECKSUM = 2'd1,
		VERDICT_NUMBER   = 2'd2,
		VERDICT_LENGTH   = 2'd3
	} verdict_t;

	typedef enum logic [1:0] {
		PH_FIRST  = 2'd0,
		PH_DIGITS = 2'd1,
		PH_ENDED  = 2'd2,
		PH_BAD    = 2'd3
	} phase_t;

	typedef struct packed {
		verdict_t          verdict;
		logic [NUM_W-1:0]  number;
	} dgram_rec_t;

	typedef struct packed {
		logic full;
		logic empty;
	} queue_status_t;

endpackage

// ----- hw/rtl/dic_front.sv -----
module dic_front
	import dic_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [LEN_W-1:0] cfg_wdata,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [7:0]       s_tdata,
	input  logic             s_tlast,
	input  queue_status_t    q_status,
	output logic             push,
	output dgram_rec_t       push_rec
);

	logic [LEN_W-1:0] packet_length_q;
	logic [LEN_W-1:0] pos_q;
	logic [7:0]       sum_q;
	logic [NUM_W-1:0] number_q;
	phase_t           phase_q;

	logic             accept;
	logic             digit;
	logic             in_field;
	logic [POS_W-1:0] pos_ext;
	logic [POS_W-1:0] len_ext;
	logic [NUM_W-1:0] number_times10;
	logic [NUM_W-1:0] number_next;
	phase_t           phase_next;

	assign s_tready = !q_status.full;
	assign accept   = s_tvalid && s_tready;

	assign pos_ext = {1'b0, pos_q};
	assign len_ext = {1'b0, packet_length_q};
	assign digit   = (s_tdata >= 8'h30) && (s_tdata <= 8'h39);

	// The number field is the run of bytes just before the checksum byte.
	assign in_field = (pos_ext + POS_W'(2) <= len_ext) &&
		(pos_ext + POS_W'(1) + POS_W'(NUMBER_FIELD_BYTES) >= len_ext);

	assign number_times10 = {number_q[NUM_W-4:0], 3'b000} + {number_q[NUM_W-2:0], 1'b0};

	always_comb begin
		phase_next  = phase_q;
		number_next = number_q;
		if (in_field) begin
			unique case (phase_q)
				PH_FIRST: begin
					if (digit) begin
						number_next = NUM_W'(s_tdata[3:0]);
						phase_next  = PH_DIGITS;
					end else begin
						phase_next = PH_BAD;
					end
				end
				PH_DIGITS: begin
					if (digit) begin
						number_next = number_times10 + NUM_W'(s_tdata[3:0]);
					end else if (s_tdata == 8'h00) begin
						phase_next = PH_ENDED;
					end else begin
						phase_next = PH_BAD;
					end
				end
				PH_ENDED, PH_BAD: begin
					phase_next = phase_q;
				end
				default: begin
					phase_next = phase_q;
				end
			endcase
		end
	end

	always_comb begin
		push_rec.number = number_q;
		priority if (pos_ext + POS_W'(1) != len_ext) begin
			push_rec.verdict = VERDICT_LENGTH;
		end else if (sum_q != s_tdata) begin
			push_rec.verdict = VERDICT_CHECKSUM;
		end else if (phase_q != PH_DIGITS && phase_q != PH_ENDED) begin
			push_rec.verdict = VERDICT_NUMBER;
		end else begin
			push_rec.verdict = VERDICT_OK;
		end
	end

	assign push = accept && s_tlast;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			packet_length_q <= LEN_RESET;
		end else if (cfg_we) begin
			packet_length_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			sum_q    <= '0;
			number_q <= '0;
			phase_q  <= PH_FIRST;
		end else if (accept) begin
			if (s_tlast) begin
				pos_q    <= '0;
				sum_q    <= '0;
				number_q <= '0;
				phase_q  <= PH_FIRST;
			end else begin
				// Position sticks at its top so overlong datagrams never match.
				if (pos_q != POS_MAX) begin
					pos_q <= pos_q + LEN_W'(1);
				end
				sum_q    <= sum_q + s_tdata;
				number_q <= number_next;
				phase_q  <= phase_next;
			end
		end
	end

endmodule

// ----- hw/rtl/dic_queue.sv -----
module dic_queue
	import dic_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  dgram_rec_t    push_rec,
	input  logic          pop,
	output dgram_rec_t    head_rec,
	output queue_status_t status
);

	dgram_rec_t        rec_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   count_q;

	logic do_push;
	logic do_pop;

	assign status.full  = (count_q == (QPTR_W+1)'(QUEUE_DEPTH));
	assign status.empty = (count_q == '0);
	assign do_push      = push && !status.full;
	assign do_pop       = pop && !status.empty;
	assign head_rec     = rec_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			rec_q[wr_ptr_q] <= push_rec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			unique case ({do_push, do_pop})
				2'b10:   count_q <= count_q + (QPTR_W+1)'(1);
				2'b01:   count_q <= count_q - (QPTR_W+1)'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ----- hw/rtl/dic_back.sv -----
module dic_back
	import dic_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  queue_status_t    q_status,
	input  dgram_rec_t       head_rec,
	output logic             pop,
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [OUT_W-1:0] m_tdata
);

	logic [NUM_W-1:0] expected_q;
	logic [CNT_W-1:0] broken_q;
	logic [CNT_W-1:0] lost_q;
	logic             m_tvalid_q;
	logic [OUT_W-1:0] m_tdata_q;

	logic [NUM_W-1:0] expected_base;
	logic [NUM_W-1:0] expected_inc;
	logic [NUM_W-1:0] seq_out;
	logic [CNT_W-1:0] broken_next;
	logic [CNT_W-1:0] lost_next;
	logic             update_seq;

	assign pop = !q_status.empty && (!m_tvalid_q || m_tready);

	// Number zero restarts the tracker before it advances.
	assign expected_base = (head_rec.number == '0) ? '0 : expected_q;
	assign expected_inc  = expected_base + NUM_W'(1);
	assign update_seq    = (head_rec.verdict == VERDICT_OK);

	always_comb begin
		broken_next = broken_q;
		lost_next   = lost_q;
		seq_out     = '0;
		unique case (head_rec.verdict)
			VERDICT_OK: begin
				seq_out = head_rec.number;
				if (expected_inc != head_rec.number) begin
					lost_next = lost_q + CNT_W'(1);
				end
			end
			VERDICT_CHECKSUM, VERDICT_NUMBER: begin
				broken_next = broken_q + CNT_W'(1);
			end
			VERDICT_LENGTH: begin
				broken_next = broken_q;
			end
			default: begin
				broken_next = broken_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_q <= '0;
			broken_q   <= '0;
			lost_q     <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (pop) begin
				// Tracker either advanced onto the number or resynchronised to it.
				if (update_seq) begin
					expected_q <= head_rec.number;
				end
				broken_q   <= broken_next;
				lost_q     <= lost_next;
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			m_tdata_q <= {lost_next, broken_next, seq_out, head_rec.verdict};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

// ----- hw/rtl/datagram_integrity_checker.sv -----
// Channel   Direction  Handshake             Contents
// s_*       in         s_tvalid / s_tready   one datagram byte per word, tlast on checksum byte
// m_*       out        m_tvalid / m_tready   one verdict word per datagram
// cfg_*     in         cfg_we                required datagram length
//
// Bytes are taken one per cycle while the queue is not full; a datagram's verdict word
// is registered in the queue and then in the output register before it turns valid.
// The sustained rate is one byte per cycle while s_tready is high, set by the front end's byte loop.
// Reset (arst_n low) sets the length to 1440 and clears counters and the tracker.
// A stalled output holds its word; the two-entry queue absorbs the next verdicts and
// s_tready drops only when it is full.
module datagram_integrity_checker
	import dic_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [LEN_W-1:0] cfg_wdata,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [7:0]       s_tdata,   // [7:0] data_byte
	input  logic             s_tlast,   // end_of_datagram
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [OUT_W-1:0] m_tdata    // [1:0] verdict, [55:2] sequence_number,
	                                    // [87:56] broken_total, [119:88] lost_total
);

	queue_status_t q_status;
	logic          push;
	logic          pop;
	dgram_rec_t    push_rec;
	dgram_rec_t    head_rec;

	dic_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.q_status  (q_status),
		.push      (push),
		.push_rec  (push_rec)
	);

	dic_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_rec (push_rec),
		.pop      (pop),
		.head_rec (head_rec),
		.status   (q_status)
	);

	dic_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_status (q_status),
		.head_rec (head_rec),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule

// ----- hw/rtl/dic_checker.sv -----
module dic_checker
	import dic_pkg::*;
(
	input logic             clk,
	input logic             arst_n,
	input logic             s_tready,
	input logic             m_tvalid,
	input logic             m_tready,
	input logic [OUT_W-1:0] m_tdata
);

	// A stalled verdict word stays put.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("verdict word changed while stalled");

	// Only accepted datagrams carry a number.
	a_seq_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[1:0] != VERDICT_OK) |-> (m_tdata[55:2] == '0))
		else $error("sequence number set on a rejected datagram");

	// Input backpressure only happens while the output holds a valid word.
	a_ready_low: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid)
		else $error("input stalled with output idle");

	// Once reset has been seen at an edge, the output is idle at the next one.
	a_reset_idle: assert property (@(posedge clk)
		!arst_n |=> !m_tvalid)
		else $error("output valid during reset");

endmodule

bind datagram_integrity_checker dic_checker u_dic_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
